// File: src/tta_pkg.sv
// tta_pkg: shared types, constants and helpers for the terminal transmit arbiter
// no dependencies
package tta_pkg;

  localparam int TERMINALS_DEF   = 4;
  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int MAX_CHUNK_DEF   = 1024;

  localparam int LIMIT_W = 11;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

  // input word: req_type, terminal, writer_id, buffer_address, byte_length
  localparam int IN_W  = 72;
  // output word: result_kind, out_terminal, out_writer, chunk_address, out_count
  localparam int OUT_W = 72;

  typedef enum logic [1:0] {
    KIND_ERROR = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_CHUNK = 2'd2
  } kind_t;

  typedef enum logic {
    REQ_WRITE   = 1'b0,
    REQ_TX_DONE = 1'b1
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_QREAD,
    ST_EMIT1,
    ST_EMIT2
  } state_t;

  // one result word
  typedef struct packed {
    kind_t       kind;
    logic [3:0]  term;
    logic [15:0] writer;
    logic [31:0] addr;
    logic [15:0] count;
  } result_t;

  // per terminal owner record held in the state memory
  typedef struct packed {
    logic        valid;
    logic [15:0] writer;
    logic [31:0] base;
    logic [15:0] total;
    logic [15:0] sent;
    logic [12:0] last_len;
  } owner_t;

endpackage

// File: src/tta_owner_mem.sv
// tta_owner_mem: owner record memory, one entry per terminal, registered read
// depends on tta_pkg
module tta_owner_mem #(
  parameter int TERMINALS = tta_pkg::TERMINALS_DEF,
  parameter int TW = (TERMINALS > 1) ? $clog2(TERMINALS) : 1
) (
  input  logic             clk,
  input  logic [TW-1:0]    rd_addr,
  output tta_pkg::owner_t  rd_data,
  input  logic             wr_en,
  input  logic [TW-1:0]    wr_addr,
  input  tta_pkg::owner_t  wr_data,
  input  logic             rst
);
  import tta_pkg::*;

  owner_t mem [TERMINALS];
  logic [TERMINALS-1:0] vld;
  owner_t raw;
  logic   raw_vld;

  // entries read as a cleared record until written after reset
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    raw <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      raw_vld <= 1'b0;
    end else begin
      if (wr_en) vld[wr_addr] <= 1'b1;
      raw_vld <= vld[rd_addr];
    end
  end

  assign rd_data = raw_vld ? raw : '0;
endmodule

// File: src/tta_queue_mem.sv
// tta_queue_mem: waiter fifo storage for all terminals, registered read
// depends on tta_pkg
module tta_queue_mem #(
  parameter int DEPTH = 32,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic [AW-1:0] rd_addr,
  output logic [63:0]   rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [63:0]   wr_data
);
  import tta_pkg::*;

  logic [63:0] mem [DEPTH];

  // single write port, single registered read port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
endmodule

// File: src/terminal_transmit_arbiter_unit.sv
// terminal_transmit_arbiter_unit: top level, sequencer around owner and queue memories
// depends on tta_pkg, tta_owner_mem, tta_queue_mem
//
// One item is worked on at a time. The terminal's owner record is read while
// the item is accepted, and ST_READ decides. Each result word then goes out
// from ST_EMIT1 or ST_EMIT2 once the receiver is ready. A queued write has no
// result word but still passes through the output slot, ST_EMIT1. A
// transmit-done that finishes an owner and starts a waiter also passes through
// ST_QREAD, which reads the waiter fifo memory. These states come from the
// registered reads of the owner and fifo memories. Receiver stalls hold the
// output states. Results leave through an output register; no clearing pass
// is needed after reset.
module terminal_transmit_arbiter_unit #(
  parameter int TERMINALS   = tta_pkg::TERMINALS_DEF,
  parameter int QUEUE_DEPTH = tta_pkg::QUEUE_DEPTH_DEF,
  parameter int MAX_CHUNK   = tta_pkg::MAX_CHUNK_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  // tdata: terminal[3:0], writer_id[19:4], buffer_address[51:20], byte_length[67:52]
  input  logic [tta_pkg::IN_W-1:0] s_tdata,
  // tuser: req_type
  input  logic                    s_tuser,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  // tdata: out_terminal[3:0], out_writer[19:4], chunk_address[51:20], out_count[67:52]
  output logic [tta_pkg::OUT_W-1:0] m_tdata,
  // tuser: result_kind
  output logic [1:0]              m_tuser,
  output logic                    m_tlast,
  input  logic                    cfg_we,
  input  logic [tta_pkg::LIMIT_W-1:0] cfg_wdata
);
  import tta_pkg::*;

  localparam int TW  = (TERMINALS > 1) ? $clog2(TERMINALS) : 1;
  localparam int QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW  = $clog2(QUEUE_DEPTH + 1);
  localparam int QMD = TERMINALS * QUEUE_DEPTH;
  localparam int QAW = (QMD > 1) ? $clog2(QMD) : 1;
  localparam logic [16:0] MAXC = 17'(MAX_CHUNK);

  state_t state, state_next;

  logic [LIMIT_W-1:0] chunk_limit;
  logic [QW-1:0] qhead [TERMINALS];
  logic [FW-1:0] qfill [TERMINALS];

  // latched request
  logic        r_type;
  logic [3:0]  r_term;
  logic [15:0] r_writer;
  logic [31:0] r_addr;
  logic [15:0] r_len;

  owner_t o_rd, o_wr;
  logic   o_we;
  logic [63:0] q_rd;
  logic        q_we;
  logic [QAW-1:0] q_waddr, q_raddr;

  result_t res1, res2;
  logic    two;
  logic    emit_pending;

  logic [TW-1:0] tix;
  logic [TW-1:0] o_raddr;
  logic          term_ok;
  assign tix     = r_term[TW-1:0];
  assign term_ok = (32'(r_term) < 32'(TERMINALS));

  // owner read starts on the incoming word so the record is ready in ST_READ
  assign o_raddr = (state == ST_IDLE) ? s_tdata[TW-1:0] : tix;

  tta_owner_mem #(.TERMINALS(TERMINALS), .TW(TW)) u_owner (
    .clk(clk), .rst(rst), .rd_addr(o_raddr), .rd_data(o_rd),
    .wr_en(o_we), .wr_addr(tix), .wr_data(o_wr)
  );

  tta_queue_mem #(.DEPTH(QMD), .AW(QAW)) u_queue (
    .clk(clk), .rd_addr(q_raddr), .rd_data(q_rd),
    .wr_en(q_we), .wr_addr(q_waddr), .wr_data({r_writer, r_addr, r_len})
  );

  // effective chunk limit
  logic [16:0] lim;
  always_comb begin
    lim = {6'd0, chunk_limit};
    if (lim == 17'd0) lim = 17'd1;
    if (lim > MAXC) lim = MAXC;
  end

  // slot addresses
  logic [QW:0] tail_sum;
  logic [QW-1:0] tail;
  always_comb begin
    tail_sum = {1'b0, qhead[tix]} + (QW+1)'(qfill[tix]);
    if (tail_sum >= (QW+1)'(QUEUE_DEPTH)) tail_sum = tail_sum - (QW+1)'(QUEUE_DEPTH);
    tail = tail_sum[QW-1:0];
  end
  assign q_waddr = QAW'(tix * QUEUE_DEPTH + 32'(tail));
  assign q_raddr = QAW'(tix * QUEUE_DEPTH + 32'(qhead[tix]));

  // next owner state after a transmit done
  logic [15:0] sent_new;
  assign sent_new = o_rd.sent + 16'(o_rd.last_len);

  function automatic logic [15:0] min_chunk(input logic [15:0] rem, input logic [16:0] l);
    min_chunk = ({1'b0, rem} < l) ? rem : l[15:0];
  endfunction

  // sequencer
  always_comb begin
    state_next = state;
    o_we = 1'b0;
    o_wr = o_rd;
    q_we = 1'b0;
    unique case (state)
      ST_IDLE:  if (s_tvalid) state_next = ST_READ;
      ST_READ: begin
        if (r_type == REQ_WRITE) begin
          if (term_ok && r_addr != 32'd0 && r_len != 16'd0) begin
            if (!o_rd.valid) begin
              o_we = 1'b1;
              o_wr.valid = 1'b1; o_wr.writer = r_writer; o_wr.base = r_addr;
              o_wr.total = r_len; o_wr.sent = 16'd0;
              o_wr.last_len = 13'(min_chunk(r_len, lim));
            end else if (32'(qfill[tix]) < 32'(QUEUE_DEPTH)) begin
              q_we = 1'b1;
            end
          end
          state_next = ST_EMIT1;
        end else if (!term_ok || !o_rd.valid) begin
          state_next = ST_IDLE;
        end else if (sent_new < o_rd.total) begin
          o_we = 1'b1;
          o_wr.sent = sent_new;
          o_wr.last_len = 13'(min_chunk(o_rd.total - sent_new, lim));
          state_next = ST_EMIT1;
        end else if (qfill[tix] != '0) begin
          state_next = ST_QREAD;
        end else begin
          o_we = 1'b1;
          o_wr.valid = 1'b0;
          o_wr.sent = sent_new;
          state_next = ST_EMIT1;
        end
      end
      ST_QREAD: begin
        o_we = 1'b1;
        o_wr.valid = 1'b1; o_wr.writer = q_rd[63:48]; o_wr.base = q_rd[47:16];
        o_wr.total = q_rd[15:0]; o_wr.sent = 16'd0;
        o_wr.last_len = 13'(min_chunk(q_rd[15:0], lim));
        state_next = ST_EMIT1;
      end
      ST_EMIT1: if (!emit_pending) state_next = ST_IDLE;
                else if (m_tready && two) state_next = ST_EMIT2;
                else if (m_tready) state_next = ST_IDLE;
      ST_EMIT2: if (m_tready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // state, chunk limit and fifo pointer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      chunk_limit <= LIMIT_RESET;
      for (int i = 0; i < TERMINALS; i++) begin
        qhead[i] <= '0;
        qfill[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_we) chunk_limit <= cfg_wdata;
      if (q_we) qfill[tix] <= qfill[tix] + FW'(1);
      if (state == ST_QREAD) begin
        qfill[tix] <= qfill[tix] - FW'(1);
        qhead[tix] <= (32'(qhead[tix]) == QUEUE_DEPTH - 1) ? '0 : qhead[tix] + QW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      r_type   <= s_tuser;
      r_term   <= s_tdata[3:0];
      r_writer <= s_tdata[19:4];
      r_addr   <= s_tdata[51:20];
      r_len    <= s_tdata[67:52];
    end
    if (state == ST_READ) begin
      two <= 1'b0;
      if (r_type == REQ_WRITE) begin
        if (!term_ok || r_addr == 32'd0)
          res1 <= '{KIND_ERROR, r_term, r_writer, 32'd0, 16'd0};
        else if (r_len == 16'd0)
          res1 <= '{KIND_DONE, r_term, r_writer, 32'd0, 16'd0};
        else if (!o_rd.valid)
          res1 <= '{KIND_CHUNK, r_term, r_writer, r_addr, min_chunk(r_len, lim)};
        else
          res1 <= '{KIND_ERROR, r_term, r_writer, 32'd0, 16'd0};
      end else if (sent_new < o_rd.total) begin
        res1 <= '{KIND_CHUNK, r_term, o_rd.writer, o_rd.base + 32'(sent_new),
                  min_chunk(o_rd.total - sent_new, lim)};
      end else begin
        res1 <= '{KIND_DONE, r_term, o_rd.writer, 32'd0, o_rd.total};
      end
    end
    if (state == ST_QREAD) begin
      two  <= 1'b1;
      res2 <= '{KIND_CHUNK, r_term, q_rd[63:48], q_rd[47:16], min_chunk(q_rd[15:0], lim)};
    end
  end

  // queued writes produce no result
  always_ff @(posedge clk) begin
    if (rst) emit_pending <= 1'b0;
    else if (state == ST_READ)
      emit_pending <= !(r_type == REQ_WRITE && term_ok && r_addr != 32'd0 && r_len != 16'd0
                        && o_rd.valid && 32'(qfill[tix]) < 32'(QUEUE_DEPTH));
  end

  result_t outw;
  assign outw     = (state == ST_EMIT2) ? res2 : res1;
  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_EMIT2) || (state == ST_EMIT1 && emit_pending);
  assign m_tdata  = {4'd0, outw.count, outw.addr, outw.writer, outw.term};
  assign m_tuser  = outw.kind;
  assign m_tlast  = (state == ST_EMIT2) || !two;

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> 32'(qfill[tix]) <= QUEUE_DEPTH) else $error("fifo fill above depth");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !s_tready) else $error("accept while busy");
  a_qread_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == ST_QREAD |-> qfill[tix] != '0) else $error("pop of empty fifo");
  a_emit2_chunk: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT2 |-> res2.kind == KIND_CHUNK) else $error("second word not chunk");
`endif
endmodule
